// ===== rtl/kmp_pkg.sv =====
// Shared types and codes for the KMP pattern matcher.
// Used by the matcher top and the output buffer; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

    // Width of the reported match start position.
    localparam int START_W = 32;

    // Operation carried by an input beat.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_START  = 2'd2,
        OP_TEXT   = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_MATCH    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_IGNORED  = 3'd3,
        ST_ACCEPTED = 3'd4,
        ST_ERROR    = 3'd5
    } status_t;

    // Controller state.
    typedef enum logic {
        S_IDLE,
        S_STEP
    } fsm_t;

    // One result beat as it travels from the controller to the output buffer.
    typedef struct packed {
        status_t             status;
        logic [START_W-1:0]  match_start;
    } result_t;

endpackage : kmp_pkg

`default_nettype wire

// ===== rtl/kmp_pattern_matcher.sv =====
// KMP pattern matcher, top level. Clear, start, first pattern byte, error and ignored
// beats give their result from the idle state; any other append or a text beat moves
// to the step state and takes one failure-table fallback step per cycle there, reading
// the pattern and failure-table RAMs (registered read). One beat is in work at a time;
// over a text stream the fallback steps average at most one per byte. Reset (asynchronous,
// active low) clears the control state at once; the RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module kmp_pattern_matcher
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN   = 64,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic [1:0]          opcode,
    input  wire logic [7:0]          symbol,
    input  wire logic                end_of_text,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic [2:0]               status,
    output logic [START_W-1:0]       match_start
);

    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int SW    = (POSITION_BITS > START_W) ? POSITION_BITS : START_W;

    fsm_t                     state_reg, state_next;
    logic [IDX_W-1:0]         cur_reg, cur_next;
    logic [7:0]               sym_reg, sym_next;
    logic                     last_reg, last_next;
    logic                     text_reg, text_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [IDX_W-1:0]         build_reg, build_next;
    logic [IDX_W-1:0]         j_reg, j_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     done_reg, done_next;

    logic                     item_fire;
    logic                     spare_full;
    logic                     res_push;
    result_t                  res_data;
    result_t                  out_data;

    logic                     pat_we;
    logic [IDX_W-1:0]         pat_waddr;
    logic [7:0]               pat_wdata;
    logic [7:0]               pat_rdata;
    logic                     fb_we;
    logic [IDX_W-1:0]         fb_waddr;
    logic [IDX_W-1:0]         fb_wdata;
    logic [IDX_W-1:0]         fb_rdata;
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         fb_raddr;

    logic                     sym_eq;
    logic [IDX_W-1:0]         cur_inc;
    logic                     len_full;
    logic                     at_end;
    logic [POSITION_BITS-1:0] pos_sat;
    logic [SW-1:0]            pos_w;
    logic [SW-1:0]            cur_w;
    logic [SW-1:0]            start_w;

    assign item_stall = (state_reg != S_IDLE) || spare_full;
    assign item_fire  = item_valid && !item_stall;

    // Pattern bytes and failure table, both read at the current progress.
    kmp_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pattern_ram (
        .clk     (clk),
        .wr_en   (pat_we),
        .wr_addr (pat_waddr),
        .wr_data (pat_wdata),
        .rd_addr (rd_addr),
        .rd_data (pat_rdata)
    );

    kmp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PATTERN)) u_fallback_ram (
        .clk     (clk),
        .wr_en   (fb_we),
        .wr_addr (fb_waddr),
        .wr_data (fb_wdata),
        .rd_addr (fb_raddr),
        .rd_data (fb_rdata)
    );

    // The failure entry for progress k lives at k - 1.
    assign fb_raddr = rd_addr - IDX_W'(1);

    // Step datapath: compare, completion test, saturated position and start.
    assign sym_eq   = (pat_rdata == sym_reg);
    assign cur_inc  = cur_reg + IDX_W'(1);
    assign len_full = (len_reg >= LEN_W'(MAX_PATTERN));
    assign at_end   = sym_eq && ((LEN_W'(cur_reg) + LEN_W'(1)) == len_reg);
    assign pos_sat  = (pos_reg == {POSITION_BITS{1'b1}}) ? pos_reg
                                                         : pos_reg + POSITION_BITS'(1);
    assign pos_w    = SW'(pos_reg);
    assign cur_w    = SW'(cur_reg);
    assign start_w  = (pos_w >= cur_w) ? (pos_w - cur_w) : '0;

    // Next state, memory accesses and result.
    always_comb
    begin
        state_next           = state_reg;
        cur_next             = cur_reg;
        sym_next             = sym_reg;
        last_next            = last_reg;
        text_next            = text_reg;
        len_next             = len_reg;
        build_next           = build_reg;
        j_next               = j_reg;
        pos_next             = pos_reg;
        done_next            = done_reg;
        pat_we               = 1'b0;
        pat_waddr            = len_reg[IDX_W-1:0];
        pat_wdata            = symbol;
        fb_we                = 1'b0;
        fb_waddr             = len_reg[IDX_W-1:0];
        fb_wdata             = '0;
        rd_addr              = cur_reg;
        res_push             = 1'b0;
        res_data.status      = ST_ACCEPTED;
        res_data.match_start = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    sym_next  = symbol;
                    last_next = end_of_text;
                    unique case (op_t'(opcode))
                        OP_CLEAR:
                        begin
                            len_next   = '0;
                            build_next = '0;
                            j_next     = '0;
                            pos_next   = '0;
                            done_next  = 1'b0;
                            res_push   = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            if (len_full)
                            begin
                                res_push        = 1'b1;
                                res_data.status = ST_ERROR;
                            end
                            else if (len_reg == '0)
                            begin
                                // First byte: its border is empty, no walk needed.
                                pat_we     = 1'b1;
                                fb_we      = 1'b1;
                                build_next = '0;
                                len_next   = LEN_W'(1);
                                res_push   = 1'b1;
                            end
                            else
                            begin
                                pat_we     = 1'b1;
                                cur_next   = build_reg;
                                rd_addr    = build_reg;
                                text_next  = 1'b0;
                                state_next = S_STEP;
                            end
                        end
                        OP_START:
                        begin
                            j_next    = '0;
                            pos_next  = '0;
                            done_next = 1'b0;
                            res_push  = 1'b1;
                            if (len_reg == '0)
                            begin
                                res_data.status = ST_ERROR;
                            end
                        end
                        OP_TEXT:
                        begin
                            if (done_reg)
                            begin
                                res_push        = 1'b1;
                                res_data.status = ST_IGNORED;
                            end
                            else if (len_reg == '0)
                            begin
                                res_push        = 1'b1;
                                res_data.status = ST_ERROR;
                            end
                            else
                            begin
                                cur_next   = j_reg;
                                rd_addr    = j_reg;
                                text_next  = 1'b1;
                                state_next = S_STEP;
                            end
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                if (!sym_eq && (cur_reg != '0))
                begin
                    // Mismatch: fall back and read the shorter prefix next cycle.
                    cur_next = fb_rdata;
                    rd_addr  = fb_rdata;
                end
                else
                begin
                    state_next = S_IDLE;
                    res_push   = 1'b1;
                    if (!text_reg)
                    begin
                        // Close the append: record the border of the new prefix.
                        fb_we      = 1'b1;
                        fb_wdata   = sym_eq ? cur_inc : cur_reg;
                        build_next = sym_eq ? cur_inc : cur_reg;
                        len_next   = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        pos_next = pos_sat;
                        if (at_end)
                        begin
                            res_data.status      = ST_MATCH;
                            res_data.match_start = start_w[START_W-1:0];
                            done_next            = 1'b1;
                            j_next               = '0;
                        end
                        else
                        begin
                            j_next          = sym_eq ? cur_inc : cur_reg;
                            res_data.status = ST_NONE;
                            if (last_reg)
                            begin
                                res_data.status = ST_NOTFOUND;
                                done_next       = 1'b1;
                            end
                        end
                    end
                end
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            build_reg <= '0;
            j_reg     <= '0;
            pos_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            build_reg <= build_next;
            j_reg     <= j_next;
            pos_reg   <= pos_next;
            done_reg  <= done_next;
        end
    end

    // Working registers of the beat in progress.
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
        text_reg <= text_next;
    end

    // Result buffer towards the output channel.
    kmp_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (res_push),
        .push_data    (res_data),
        .spare_full   (spare_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (out_data)
    );

    assign status      = out_data.status;
    assign match_start = out_data.match_start;

    // Match progress stays inside the stored pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) |-> (LEN_W'(j_reg) < len_reg))
        else $error("match progress reached the pattern length");

    // The border of the stored pattern is always a proper prefix.
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) |-> (LEN_W'(build_reg) < len_reg))
        else $error("build progress reached the pattern length");

    // The pattern never grows past its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    // A reported match closes the search.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res_data.status == ST_MATCH)) |=> done_reg)
        else $error("search not closed after a match");

endmodule : kmp_pattern_matcher

`default_nettype wire

// ===== rtl/kmp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule : kmp_ram

`default_nettype wire

// ===== rtl/kmp_out_buf.sv =====
// Result buffer: an output register backed by one spare slot, so that the
// controller can take a new beat while a finished result waits. Uses kmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmp_out_buf
    import kmp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         spare_full,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result_data
);

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t pend_data_reg, pend_data_next;
    logic    out_free;

    // The output register can take a beat when empty or when it drains now.
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        if (out_free)
        begin
            // The spare slot is older than a new push, so it goes out first.
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = pend_data_reg;
                pend_valid_next = push;
                pend_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            pend_valid_next = 1'b1;
            pend_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        pend_data_reg <= pend_data_next;
    end

    assign spare_full   = pend_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule : kmp_out_buf

`default_nettype wire

// ===== tb/kmp_checker.sv =====
// Scoreboard for the KMP pattern matcher: watches both channels, predicts each result
// from its own copy of the pattern, failure table and search state, and compares.
// Depends on kmp_pkg for the operation and status codes and the result struct.
`timescale 1ns / 1ps

module kmp_checker
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN   = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  logic [1:0]         opcode,
    input  logic [7:0]         symbol,
    input  logic               end_of_text,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic [2:0]         status,
    input  logic [START_W-1:0] match_start,
    output int                 fail_count,
    output int                 pending,
    output int                 checked_count,
    output int                 match_count
);

    localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS) - 64'd1;

    // Shadow copy of the matcher state.
    logic [7:0]      pat_mem [0:MAX_PATTERN-1];
    int unsigned     fail_tab [0:MAX_PATTERN-1];
    int unsigned     pat_len;
    int unsigned     build_k;
    int unsigned     match_j;
    longint unsigned text_pos;
    logic            search_over;

    // Results still owed by the block, oldest first.
    result_t owed_results [$];

    // Apply one input beat to the shadow state and return the result it should give.
    function automatic result_t match_step(input op_t op, input logic [7:0] sym,
                                           input logic last);
        result_t     r;
        int unsigned k;
        int unsigned j;
        r.status      = ST_ACCEPTED;
        r.match_start = '0;
        case (op)
            OP_CLEAR:
            begin
                pat_len     = 0;
                build_k     = 0;
                match_j     = 0;
                text_pos    = 0;
                search_over = 1'b0;
            end
            OP_APPEND:
            begin
                if (pat_len >= MAX_PATTERN)
                begin
                    r.status = ST_ERROR;
                end
                else
                begin
                    // Extend the border table with the same fallback walk as the search.
                    k = build_k;
                    pat_mem[pat_len] = sym;
                    if (pat_len == 0)
                    begin
                        fail_tab[0] = 0;
                        k = 0;
                    end
                    else
                    begin
                        while (k > 0 && pat_mem[k] != sym)
                            k = fail_tab[k-1];
                        if (pat_mem[k] == sym)
                            k++;
                        fail_tab[pat_len] = k;
                    end
                    build_k = k;
                    pat_len++;
                end
            end
            OP_START:
            begin
                match_j     = 0;
                text_pos    = 0;
                search_over = 1'b0;
                if (pat_len == 0)
                    r.status = ST_ERROR;
            end
            default:
            begin
                if (search_over)
                begin
                    r.status = ST_IGNORED;
                end
                else if (pat_len == 0)
                begin
                    r.status = ST_ERROR;
                end
                else
                begin
                    // Fall back through the table until the byte fits or progress is nil.
                    j = match_j;
                    while (j > 0 && pat_mem[j] != sym)
                        j = fail_tab[j-1];
                    r.status = ST_NONE;
                    if (pat_mem[j] == sym)
                    begin
                        if (j + 1 == pat_len)
                        begin
                            r.status      = ST_MATCH;
                            r.match_start = START_W'((text_pos >= j) ? text_pos - j : 0);
                            search_over   = 1'b1;
                            j = 0;
                        end
                        else
                        begin
                            j++;
                        end
                    end
                    match_j = j;
                    // A match on the final byte takes precedence over not found.
                    if (r.status != ST_MATCH && last)
                    begin
                        r.status    = ST_NOTFOUND;
                        search_over = 1'b1;
                    end
                    if (text_pos < POS_MAX)
                        text_pos++;
                end
            end
        endcase
        return r;
    endfunction

    // Compare each result beat with the oldest prediction, then log new input beats.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            pat_len       = 0;
            build_k       = 0;
            match_j       = 0;
            text_pos      = 0;
            search_over   = 1'b0;
            owed_results.delete();
            pending       = 0;
            fail_count    = 0;
            checked_count = 0;
            match_count   = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat: expected none, got status %0d start %0d",
                             $time, status, match_start);
                end
                else
                begin
                    want = owed_results.pop_front();
                    checked_count++;
                    if (want.status == ST_MATCH)
                        match_count++;
                    if (status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, status);
                    end
                    if (match_start !== want.match_start)
                    begin
                        fail_count++;
                        $display("%0t: match_start mismatch: expected %0d, actual %0d",
                                 $time, want.match_start, match_start);
                    end
                end
            end
            if (item_valid && !item_stall)
                owed_results.push_back(match_step(op_t'(opcode), symbol, end_of_text));
            pending = owed_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the KMP pattern matcher: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on kmp_pkg, kmp_pattern_matcher and kmp_checker.
`timescale 1ns / 1ps

module tb;
    import kmp_pkg::*;

    localparam int MAX_PATTERN   = 64;
    localparam int POSITION_BITS = 32;
    localparam int RANDOM_BEATS  = 950;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [1:0]         opcode;
    logic [7:0]         symbol;
    logic               end_of_text;
    logic               result_valid;
    logic               result_stall;
    logic [2:0]         status;
    logic [START_W-1:0] match_start;

    int fail_count;
    int pending;
    int checked_count;
    int match_count;

    int   beats_sent    = 0;
    int   send_idle_pct = 24;
    int   recv_idle_pct = 76;
    logic hold_request  = 1'b0;
    int   quiet_cycles  = 0;

    // Last pattern built by the stimulus and the byte pool it was drawn from.
    logic [7:0] pat_q [$];
    logic [7:0] alphabet [0:2];

    kmp_pattern_matcher #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .symbol       (symbol),
        .end_of_text  (end_of_text),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .match_start  (match_start)
    );

    kmp_checker #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .opcode        (opcode),
        .symbol        (symbol),
        .end_of_text   (end_of_text),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .match_start   (match_start),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .match_count   (match_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or one long hold-off when the stimulus asks for it.
    initial
    begin : receiver
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Count cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("%0t: watchdog: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Offer one beat from a falling edge and return at the rising edge that takes it.
    task automatic send_beat(input op_t op, input logic [7:0] sym, input logic eot);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid  <= 1'b1;
        opcode      <= op;
        symbol      <= sym;
        end_of_text <= eot;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        beats_sent++;
    endtask

    // Stop offering and wait for every owed result.
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Clear and load a fresh pattern; mostly short, now and then full or overfull.
    task automatic build_pattern();
        int         pick;
        int         len;
        logic [7:0] sym;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            len = MAX_PATTERN + $urandom_range(0, 2);
        else if (pick < 18)
            len = $urandom_range(9, 20);
        else
            len = $urandom_range(1, 8);
        for (int a = 0; a < 3; a++)
            alphabet[a] = 8'($urandom);
        pat_q.delete();
        send_beat(OP_CLEAR, 8'($urandom), 1'($urandom));
        for (int i = 0; i < len; i++)
        begin
            sym = alphabet[$urandom_range(0, 2)];
            send_beat(OP_APPEND, sym, 1'($urandom));
            if (i < MAX_PATTERN)
                pat_q.push_back(sym);
        end
    endtask

    // Start a text and stream bytes from the pattern's pool, sometimes with the pattern
    // planted in it; the end mark usually falls on the last byte.
    task automatic search_text();
        int         tlen;
        int         plant_at;
        logic [7:0] sym;
        logic       eot;
        if ($urandom_range(0, 1) == 1)
        begin
            tlen     = pat_q.size() + $urandom_range(0, 12);
            plant_at = $urandom_range(0, tlen - pat_q.size());
        end
        else
        begin
            tlen     = $urandom_range(1, pat_q.size() + 12);
            plant_at = -1;
        end
        send_beat(OP_START, 8'($urandom), 1'($urandom));
        for (int i = 0; i < tlen; i++)
        begin
            if (plant_at >= 0 && i >= plant_at && i - plant_at < pat_q.size())
                sym = pat_q[i - plant_at];
            else if ($urandom_range(0, 9) == 0)
                sym = 8'($urandom);
            else
                sym = alphabet[$urandom_range(0, 2)];
            if (i == tlen - 1)
                eot = ($urandom_range(0, 99) < 70);
            else
                eot = ($urandom_range(0, 99) < 3);
            send_beat(OP_TEXT, sym, eot);
        end
    endtask

    // One random scenario: a full search, a new text on the same pattern, or noise.
    task automatic run_scenario();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            send_beat(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        end
        else if (pick < 40 && pat_q.size() != 0)
        begin
            search_text();
        end
        else
        begin
            build_pattern();
            search_text();
        end
    endtask

    task automatic run_phase(input int beats);
        int phase_end;
        phase_end = beats_sent + beats;
        while (beats_sent < phase_end)
            run_scenario();
        drain_results();
    endtask

    initial
    begin : stimulus
        item_valid  = 1'b0;
        opcode      = OP_CLEAR;
        symbol      = 8'h00;
        end_of_text = 1'b0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty pattern: text byte and start are both errors.
        send_beat(OP_TEXT, 8'hFF, 1'b1);
        send_beat(OP_START, 8'hFF, 1'b1);
        // Pattern 00 FF 00 has a border of one byte.
        send_beat(OP_CLEAR, 8'hFF, 1'b1);
        send_beat(OP_APPEND, 8'h00, 1'b0);
        send_beat(OP_APPEND, 8'hFF, 1'b1);
        send_beat(OP_APPEND, 8'h00, 1'b0);
        // Fallback after a partial match, match at position 1, then ignored text.
        send_beat(OP_START, 8'h00, 1'b0);
        send_beat(OP_TEXT, 8'h00, 1'b0);
        send_beat(OP_TEXT, 8'h00, 1'b0);
        send_beat(OP_TEXT, 8'hFF, 1'b0);
        send_beat(OP_TEXT, 8'h00, 1'b0);
        send_beat(OP_TEXT, 8'h55, 1'b0);
        // End of text on the matching byte: the match wins.
        send_beat(OP_START, 8'h00, 1'b0);
        send_beat(OP_TEXT, 8'h00, 1'b0);
        send_beat(OP_TEXT, 8'hFF, 1'b0);
        send_beat(OP_TEXT, 8'h00, 1'b1);
        // Not found, then text after it is ignored.
        send_beat(OP_START, 8'h00, 1'b0);
        send_beat(OP_TEXT, 8'hFF, 1'b1);
        send_beat(OP_TEXT, 8'h00, 1'b0);
        // Append in the middle of a search keeps the search state.
        send_beat(OP_START, 8'h00, 1'b0);
        send_beat(OP_TEXT, 8'h00, 1'b0);
        send_beat(OP_APPEND, 8'hFF, 1'b0);
        send_beat(OP_TEXT, 8'hFF, 1'b0);
        send_beat(OP_TEXT, 8'h00, 1'b0);
        send_beat(OP_TEXT, 8'hFF, 1'b0);
        drain_results();

        // Random traffic under three idling patterns.
        run_phase(RANDOM_BEATS / 3);
        set_idling(76, 24);
        run_phase(RANDOM_BEATS / 3);
        set_idling(0, 0);
        hold_request = 1'b1;
        run_phase(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));

        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Covered %0d input beats in directed and random searches over three idling",
                 beats_sent);
        $display("patterns; %0d results checked, %0d of them matches.", checked_count,
                 match_count);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
